### rtl/headset_jack_detect_controller_unit_defines.svh
// Assertion macros for the headset jack detect controller.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef HEADSET_JACK_DETECT_CONTROLLER_UNIT_DEFINES_SVH
`define HEADSET_JACK_DETECT_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define HJDC_ASSERT(lbl, clk_i, rstn_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
    else $error("hjdc assertion failed");
// checked at every edge, reset included
`define HJDC_ASSERT_ALWAYS(lbl, clk_i, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hjdc assertion failed");
`else
`define HJDC_ASSERT(lbl, clk_i, rstn_i, prop)
`define HJDC_ASSERT_ALWAYS(lbl, clk_i, prop)
`endif

`endif

### rtl/hjdc_pkg.sv
// Shared types and constants for the headset jack detect controller.
// No dependencies.
`default_nettype none
package hjdc_pkg;

  localparam int unsigned DELAY_BITS = 12;
  localparam int unsigned NTMR       = 5;

  // timer slots, also the expiry priority order after remove
  localparam logic [2:0] TMR_INS = 3'd0;
  localparam logic [2:0] TMR_REM = 3'd1;
  localparam logic [2:0] TMR_PRS = 3'd2;
  localparam logic [2:0] TMR_REL = 3'd3;
  localparam logic [2:0] TMR_BEN = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_INSERT_DLY = 3'd0;
  localparam logic [2:0] CFG_REMOVE_DLY = 3'd1;
  localparam logic [2:0] CFG_PRESS_DLY  = 3'd2;
  localparam logic [2:0] CFG_RELEASE_DLY = 3'd3;
  localparam logic [2:0] CFG_RETRY_INT  = 3'd4;
  localparam logic [2:0] CFG_BTN_EN_DLY = 3'd5;
  localparam logic [2:0] CFG_RETRY_LIM  = 3'd6;

  // item op codes
  localparam logic OP_IRQ  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // jack codes
  localparam logic [1:0] JACK_NONE    = 2'd0;
  localparam logic [1:0] JACK_HP      = 2'd1;
  localparam logic [1:0] JACK_HS      = 2'd2;
  localparam logic [1:0] JACK_HS_BTN  = 2'd3;

  // reset values of the configuration registers
  localparam logic [DELAY_BITS-1:0] RST_INSERT_DLY  = DELAY_BITS'(500);
  localparam logic [DELAY_BITS-1:0] RST_REMOVE_DLY  = DELAY_BITS'(500);
  localparam logic [DELAY_BITS-1:0] RST_PRESS_DLY   = DELAY_BITS'(50);
  localparam logic [DELAY_BITS-1:0] RST_RELEASE_DLY = DELAY_BITS'(50);
  localparam logic [DELAY_BITS-1:0] RST_RETRY_INT   = DELAY_BITS'(100);
  localparam logic [DELAY_BITS-1:0] RST_BTN_EN_DLY  = DELAY_BITS'(1500);
  localparam logic [3:0]            RST_RETRY_LIM   = 4'd6;

  typedef struct packed {
    logic       op;
    logic [1:0] jack_sense;
    logic       button_sense;
  } in_item_t;

  typedef struct packed {
    logic [1:0] jack_status;
    logic       report_strobe;
    logic       mic_bias_on;
    logic       button_intr_enable;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/headset_jack_detect_controller_unit.sv
// Headset jack detect controller, top level.
// Depends on hjdc_pkg and headset_jack_detect_controller_unit_defines.svh.
//
// Usage:
//  - in_valid/in_ready/in_data carry one beat per detect interrupt (op 0) or
//    per one-millisecond tick (op 1), with the sampled jack and button sense.
//  - out_valid/out_ready/out_data return exactly one beat per input beat:
//    reported jack status, report strobe, mic bias and button irq enable.
//  - cfg_valid/cfg_ready/cfg_index/cfg_data write the seven delay and retry
//    registers; cfg_ready is always high. Write only while the block is idle.
// Result: registered, visible in the cycle after its input beat is taken.
// Throughput: one beat per cycle while out_ready is high. All timer,
// handler and state updates for a beat resolve in one combinational pass
// from the state registers into the state and output registers.
// Stall: in_ready is high when the output register is empty or is being
// drained this cycle; with out_ready low and a result held, input stalls.
// Reset (rst_n low, synchronous): nothing reported, no timer pending, bias
// and button irq off, retries six, registers back to their defaults, output
// register empty.
`default_nettype none
`include "headset_jack_detect_controller_unit_defines.svh"
module headset_jack_detect_controller_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hjdc_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hjdc_pkg::out_item_t     out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [hjdc_pkg::DELAY_BITS-1:0] cfg_data
);

  localparam int unsigned DW = hjdc_pkg::DELAY_BITS;
  localparam int unsigned NT = hjdc_pkg::NTMR;

  // configuration
  logic [DW-1:0] ins_dly_r, rem_dly_r, prs_dly_r, rel_dly_r, rty_int_r, ben_dly_r;
  logic [3:0]    rty_lim_r;

  // block state
  logic [1:0]    state_r, state_nxt;
  logic          btn_ok_r, btn_ok_nxt;
  logic [3:0]    rty_r, rty_nxt;
  logic [DW-1:0] cnt_r [NT];
  logic [DW-1:0] cnt_nxt [NT];
  logic [NT-1:0] pend_r, pend_nxt;
  logic          bias_r, bias_nxt;
  logic          irq_r, irq_nxt;

  logic                out_valid_r;
  hjdc_pkg::out_item_t out_r, out_nxt;

  logic in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [NT-1:0] fired;
    logic [1:0]    jt;
    logic [1:0]    js;
    logic          bs;
    logic          strobe;
    logic          hs;

    state_nxt  = state_r;
    btn_ok_nxt = btn_ok_r;
    rty_nxt    = rty_r;
    pend_nxt   = pend_r;
    bias_nxt   = bias_r;
    irq_nxt    = irq_r;
    for (int i = 0; i < NT; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    fired  = '0;
    strobe = 1'b0;
    hs     = 1'b0;
    js     = in_data.jack_sense;
    bs     = in_data.button_sense;
    // sense code 3 counts as headphone
    jt = (js == hjdc_pkg::JACK_HS) ? hjdc_pkg::JACK_HS :
         ((js != hjdc_pkg::JACK_NONE) ? hjdc_pkg::JACK_HP : hjdc_pkg::JACK_NONE);

    if (in_data.op == hjdc_pkg::OP_IRQ) begin
      if (state_r == hjdc_pkg::JACK_NONE) begin
        rty_nxt = rty_lim_r;
        if (!pend_nxt[hjdc_pkg::TMR_INS]) begin
          pend_nxt[hjdc_pkg::TMR_INS] = 1'b1;
          cnt_nxt[hjdc_pkg::TMR_INS]  = ins_dly_r;
        end
      end else if (js == hjdc_pkg::JACK_NONE) begin
        btn_ok_nxt = 1'b0;
        if (!pend_nxt[hjdc_pkg::TMR_REM]) begin
          pend_nxt[hjdc_pkg::TMR_REM] = 1'b1;
          cnt_nxt[hjdc_pkg::TMR_REM]  = rem_dly_r;
        end
      end else if (state_r[1] && btn_ok_r) begin
        if (!pend_nxt[hjdc_pkg::TMR_PRS]) begin
          pend_nxt[hjdc_pkg::TMR_PRS] = 1'b1;
          cnt_nxt[hjdc_pkg::TMR_PRS]  = prs_dly_r;
        end
      end
      strobe = 1'b1;
    end else begin
      // count down; a count of 0 or 1 expires
      for (int i = 0; i < NT; i++) begin
        if (pend_r[i]) begin
          if (cnt_r[i][DW-1:1] == '0) begin
            cnt_nxt[i]  = '0;
            pend_nxt[i] = 1'b0;
            fired[i]    = 1'b1;
          end else begin
            cnt_nxt[i] = cnt_r[i] - DW'(1);
          end
        end
      end

      // remove runs first and cancels insert
      if (fired[hjdc_pkg::TMR_REM]) begin
        pend_nxt[hjdc_pkg::TMR_INS] = 1'b0;
        fired[hjdc_pkg::TMR_INS]    = 1'b0;
        if (state_nxt != hjdc_pkg::JACK_NONE) begin
          if (js == hjdc_pkg::JACK_NONE) begin
            btn_ok_nxt = 1'b0;
            pend_nxt[hjdc_pkg::TMR_BEN] = 1'b0;
            state_nxt  = hjdc_pkg::JACK_NONE;
            bias_nxt   = 1'b0;
            irq_nxt    = 1'b0;
          end else if (state_nxt[1] && !btn_ok_nxt) begin
            btn_ok_nxt = 1'b1;
          end
        end
        strobe = 1'b1;
      end

      if (fired[hjdc_pkg::TMR_INS]) begin
        if (jt != hjdc_pkg::JACK_NONE) begin
          if (jt == hjdc_pkg::JACK_HS) begin
            btn_ok_nxt = 1'b1;
            bias_nxt   = 1'b1;
            if (!pend_nxt[hjdc_pkg::TMR_BEN]) begin
              pend_nxt[hjdc_pkg::TMR_BEN] = 1'b1;
              cnt_nxt[hjdc_pkg::TMR_BEN]  = ben_dly_r;
            end
          end else begin
            btn_ok_nxt = 1'b0;
            bias_nxt   = 1'b0;
          end
        end
        if (rty_nxt == 4'd0) begin
          state_nxt = jt;
          strobe    = 1'b1;
        end else if (jt == hjdc_pkg::JACK_HS) begin
          rty_nxt   = 4'd0;
          state_nxt = jt;
          strobe    = 1'b1;
        end else begin
          rty_nxt = rty_nxt - 4'd1;
          if (!pend_nxt[hjdc_pkg::TMR_INS]) begin
            pend_nxt[hjdc_pkg::TMR_INS] = 1'b1;
            cnt_nxt[hjdc_pkg::TMR_INS]  = rty_int_r;
          end
        end
      end

      hs = state_nxt[1];
      if (fired[hjdc_pkg::TMR_PRS]) begin
        if (hs && btn_ok_nxt && js != hjdc_pkg::JACK_NONE && bs) begin
          state_nxt = hjdc_pkg::JACK_HS_BTN;
          strobe    = 1'b1;
          if (!pend_nxt[hjdc_pkg::TMR_REL]) begin
            pend_nxt[hjdc_pkg::TMR_REL] = 1'b1;
            cnt_nxt[hjdc_pkg::TMR_REL]  = rel_dly_r;
          end
        end
      end

      hs = state_nxt[1];
      if (fired[hjdc_pkg::TMR_REL]) begin
        if (hs && btn_ok_nxt && js != hjdc_pkg::JACK_NONE) begin
          if (!bs) begin
            state_nxt = hjdc_pkg::JACK_HS;
            strobe    = 1'b1;
          end else if (!pend_nxt[hjdc_pkg::TMR_REL]) begin
            pend_nxt[hjdc_pkg::TMR_REL] = 1'b1;
            cnt_nxt[hjdc_pkg::TMR_REL]  = rel_dly_r;
          end
        end
      end

      if (fired[hjdc_pkg::TMR_BEN]) begin
        irq_nxt = btn_ok_nxt;
      end
    end

    out_nxt.jack_status        = state_nxt;
    out_nxt.report_strobe      = strobe;
    out_nxt.mic_bias_on        = bias_nxt;
    out_nxt.button_intr_enable = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_dly_r <= hjdc_pkg::RST_INSERT_DLY;
      rem_dly_r <= hjdc_pkg::RST_REMOVE_DLY;
      prs_dly_r <= hjdc_pkg::RST_PRESS_DLY;
      rel_dly_r <= hjdc_pkg::RST_RELEASE_DLY;
      rty_int_r <= hjdc_pkg::RST_RETRY_INT;
      ben_dly_r <= hjdc_pkg::RST_BTN_EN_DLY;
      rty_lim_r <= hjdc_pkg::RST_RETRY_LIM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hjdc_pkg::CFG_INSERT_DLY:  ins_dly_r <= cfg_data;
        hjdc_pkg::CFG_REMOVE_DLY:  rem_dly_r <= cfg_data;
        hjdc_pkg::CFG_PRESS_DLY:   prs_dly_r <= cfg_data;
        hjdc_pkg::CFG_RELEASE_DLY: rel_dly_r <= cfg_data;
        hjdc_pkg::CFG_RETRY_INT:   rty_int_r <= cfg_data;
        hjdc_pkg::CFG_BTN_EN_DLY:  ben_dly_r <= cfg_data;
        hjdc_pkg::CFG_RETRY_LIM:   rty_lim_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hjdc_pkg::JACK_NONE;
      btn_ok_r    <= 1'b0;
      rty_r       <= hjdc_pkg::RST_RETRY_LIM;
      pend_r      <= '0;
      bias_r      <= 1'b0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        state_r  <= state_nxt;
        btn_ok_r <= btn_ok_nxt;
        rty_r    <= rty_nxt;
        pend_r   <= pend_nxt;
        bias_r   <= bias_nxt;
        irq_r    <= irq_nxt;
        for (int i = 0; i < NT; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  `HJDC_ASSERT_ALWAYS(a_reset_empties_out, clk, !rst_n |=> !out_valid_r)
  `HJDC_ASSERT(a_beat_gives_result, clk, rst_n, in_acc |=> out_valid_r)
  `HJDC_ASSERT(a_irq_always_reports, clk, rst_n, in_acc && in_data.op == hjdc_pkg::OP_IRQ |=> out_r.report_strobe)
  `HJDC_ASSERT(a_idle_holds_state, clk, rst_n, !in_acc |=> $stable(state_r) && $stable(pend_r) && $stable(rty_r))

endmodule
`default_nettype wire
